/* hdl/assert_macros.svh */
// Assertion macros shared by the RTL. Each expects clk and rst in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Checked only while the block is out of reset.
`define PCMB_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every edge, reset included.
`define PCMB_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`else

`define PCMB_ASSERT(label, prop, msg)
`define PCMB_ASSERT_ALWAYS(label, prop, msg)

`endif

`endif

/* hdl/pcmb_pkg.sv */
package pcmb_pkg;

  localparam int BYTE_W    = 8;
  localparam int SAMPLE_W  = 32;
  localparam int PARTIAL_W = 24;
  localparam int NBYTES_W  = 3;
  localparam int POS_W     = 2;

  localparam logic [NBYTES_W-1:0] SAMPLE_BYTES_RESET = 3'd2;
  localparam logic [NBYTES_W-1:0] NBYTES_ONE   = 3'd1;
  localparam logic [NBYTES_W-1:0] NBYTES_TWO   = 3'd2;
  localparam logic [NBYTES_W-1:0] NBYTES_THREE = 3'd3;
  localparam logic [NBYTES_W-1:0] NBYTES_FOUR  = 3'd4;

  // A completed sample on its way from the gather stage to the result register.
  typedef struct packed {
    logic                valid;
    logic [SAMPLE_W-1:0] raw;
    logic [NBYTES_W-1:0] nbytes;
    logic                last;
  } gather_out_t;

  // Gather stage status, used for checking.
  typedef struct packed {
    logic                in_full;
    logic [POS_W-1:0]    pos;
    logic [NBYTES_W-1:0] nbytes;
  } gather_status_t;

endpackage

/* hdl/pcmb_gather.sv */
module pcmb_gather (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [pcmb_pkg::BYTE_W-1:0]    byte_value,
  input  logic                           end_of_buffer,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [pcmb_pkg::NBYTES_W-1:0]  sample_bytes,
  input  logic                           out_ready,
  output pcmb_pkg::gather_out_t          gout,
  output pcmb_pkg::gather_status_t       status
);
  import pcmb_pkg::*;

  logic                 in_full;
  logic                 in_full_next;
  logic [BYTE_W-1:0]    byte_reg;
  logic                 eob_reg;
  logic [NBYTES_W-1:0]  nbytes;
  logic [PARTIAL_W-1:0] partial;
  logic [PARTIAL_W-1:0] partial_next;
  logic [POS_W-1:0]     pos;
  logic [POS_W-1:0]     pos_next;

  logic [NBYTES_W-1:0]  pos_inc;
  logic                 n_ok;
  logic                 complete;
  logic [SAMPLE_W-1:0]  shifted;
  logic [SAMPLE_W-1:0]  raw;
  logic                 step;
  logic                 accept;
  logic                 cfg_we;

  assign pos_inc  = {1'b0, pos} + NBYTES_W'(1);
  assign n_ok     = (nbytes != '0) && (nbytes <= NBYTES_FOUR);
  assign complete = n_ok && (pos_inc >= nbytes);
  assign shifted  = {{(SAMPLE_W-BYTE_W){1'b0}}, byte_reg} << {pos, 3'b000};
  assign raw      = {{(SAMPLE_W-PARTIAL_W){1'b0}}, partial} | shifted;

  // A byte that completes a sample may only leave once the result register can take it.
  assign step     = in_full && (!complete || out_ready);
  assign in_stall = in_full && !step;
  assign accept   = in_valid && !in_stall;

  assign cfg_ready = !in_full;
  assign cfg_we    = cfg_valid && cfg_ready;

  always_comb begin
    in_full_next = in_full;
    if (accept) begin
      in_full_next = 1'b1;
    end else if (step) begin
      in_full_next = 1'b0;
    end
    if (!n_ok || complete || eob_reg) begin
      partial_next = '0;
      pos_next     = '0;
    end else begin
      partial_next = raw[PARTIAL_W-1:0];
      pos_next     = pos_inc[POS_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
      nbytes  <= SAMPLE_BYTES_RESET;
      partial <= '0;
      pos     <= '0;
    end else begin
      in_full <= in_full_next;
      if (cfg_we) begin
        nbytes  <= sample_bytes;
        partial <= '0;
        pos     <= '0;
      end else if (step) begin
        partial <= partial_next;
        pos     <= pos_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      byte_reg <= byte_value;
      eob_reg  <= end_of_buffer;
    end
  end

  assign gout.valid  = step && complete;
  assign gout.raw    = raw;
  assign gout.nbytes = nbytes;
  assign gout.last   = eob_reg;

  assign status.in_full = in_full;
  assign status.pos     = pos;
  assign status.nbytes  = nbytes;

endmodule

/* hdl/pcmb_scale.sv */
module pcmb_scale (
  input  logic                                 clk,
  input  logic                                 rst,
  input  pcmb_pkg::gather_out_t                gout,
  output logic                                 out_ready,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [pcmb_pkg::SAMPLE_W-1:0] sample,
  output logic                                 last_sample
);
  import pcmb_pkg::*;

  logic                signbit;
  logic                nonzero;
  logic [SAMPLE_W-1:0] base;
  logic [SAMPLE_W-1:0] scaled;

  // v*(2^31-1)/2^(8n-1) truncated toward zero equals v*2^(32-8n) moved one step
  // towards zero, since |v| never exceeds 2^(8n-1).
  always_comb begin
    signbit = 1'b0;
    nonzero = 1'b0;
    base    = gout.raw;
    case (gout.nbytes)
      NBYTES_ONE: begin
        signbit = gout.raw[7];
        nonzero = |gout.raw[7:0];
        base    = {gout.raw[7:0], 24'b0};
      end
      NBYTES_TWO: begin
        signbit = gout.raw[15];
        nonzero = |gout.raw[15:0];
        base    = {gout.raw[15:0], 16'b0};
      end
      NBYTES_THREE: begin
        signbit = gout.raw[23];
        nonzero = |gout.raw[23:0];
        base    = {gout.raw[23:0], 8'b0};
      end
      default: begin
        base = gout.raw;
      end
    endcase
    if (gout.nbytes == NBYTES_FOUR) begin
      scaled = base;
    end else if (signbit) begin
      scaled = base + SAMPLE_W'(1);
    end else if (nonzero) begin
      scaled = base - SAMPLE_W'(1);
    end else begin
      scaled = base;
    end
  end

  assign out_ready = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_ready) begin
      out_valid <= gout.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready && gout.valid) begin
      sample      <= scaled;
      last_sample <= gout.last;
    end
  end

endmodule

/* hdl/pcm_bytes_to_s32_samples_unit.sv */
// PCM byte stream to signed 32-bit samples.
//
// Input channel: one little-endian byte per transaction on byte_value, with
// end_of_buffer marking the last byte of a buffer (a partial sample is then
// dropped). A transaction completes when in_valid is high and in_stall low.
// Output channel: one sample per completed group of sample_bytes bytes, scaled
// to full 32-bit range, with last_sample set when its final byte carried
// end_of_buffer. Transactions complete when out_valid is high and out_stall low.
// Configuration: a write on cfg_valid/cfg_ready sets sample_bytes (1 to 4) and
// restarts gathering on a sample boundary; cfg_ready is high whenever the input
// register is empty.
// Throughput is one byte per cycle while out_stall is low. A sample's last byte
// passes through the input register and then through the result register.
// When the receiver stalls, the result register holds its sample and the input
// register still takes one more byte; bytes that do not finish a sample keep
// flowing, and a completing byte waits until the result register frees.
// Synchronous reset empties both registers, clears the gathered bytes and sets
// sample_bytes to 2.
`include "assert_macros.svh"

module pcm_bytes_to_s32_samples_unit (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [pcmb_pkg::BYTE_W-1:0]          byte_value,
  input  logic                                 end_of_buffer,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [pcmb_pkg::NBYTES_W-1:0]        sample_bytes,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [pcmb_pkg::SAMPLE_W-1:0] sample,
  output logic                                 last_sample
);
  import pcmb_pkg::*;

  gather_out_t    gout;
  gather_status_t status;
  logic           out_ready;

  pcmb_gather u_gather (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .byte_value    (byte_value),
    .end_of_buffer (end_of_buffer),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .sample_bytes  (sample_bytes),
    .out_ready     (out_ready),
    .gout          (gout),
    .status        (status)
  );

  pcmb_scale u_scale (
    .clk         (clk),
    .rst         (rst),
    .gout        (gout),
    .out_ready   (out_ready),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .sample      (sample),
    .last_sample (last_sample)
  );

  `PCMB_ASSERT_ALWAYS(a_reset_empty, rst |=> !out_valid && !status.in_full, "not empty after reset")
  `PCMB_ASSERT(a_stall_needs_byte, in_stall |-> status.in_full, "stall with empty input register")
  `PCMB_ASSERT(a_cfg_restarts, cfg_valid && cfg_ready |=> status.pos == '0, "gather not restarted")
  `PCMB_ASSERT(a_one_byte_no_pos, status.nbytes == NBYTES_ONE |-> status.pos == '0, "stray position")

endmodule

/* verif/s32_sample_checker.sv */
module s32_sample_checker (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  input  logic                                 in_stall,
  input  logic [pcmb_pkg::BYTE_W-1:0]          byte_value,
  input  logic                                 end_of_buffer,
  input  logic                                 cfg_valid,
  input  logic                                 cfg_ready,
  input  logic [pcmb_pkg::NBYTES_W-1:0]        sample_bytes,
  input  logic                                 out_valid,
  input  logic                                 out_stall,
  input  logic signed [pcmb_pkg::SAMPLE_W-1:0] sample,
  input  logic                                 last_sample,
  output int                                   pending_samples,
  output int                                   fail_count
);
  import pcmb_pkg::*;

  localparam logic [63:0] FULL_SCALE = 64'h7FFF_FFFF;
  localparam int          PRINT_CAP  = 200;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] value;
    logic                       last;
  } sample_result_t;

  sample_result_t       expected_samples[$];
  logic [NBYTES_W-1:0]  size_now;
  logic [PARTIAL_W-1:0] gathered;
  logic [POS_W-1:0]     gather_pos;

  initial begin
    fail_count      = 0;
    pending_samples = 0;
  end

  task automatic report_mismatch(input string msg);
    if (fail_count < PRINT_CAP) begin
      $display("mismatch at %0t: %s", $realtime, msg);
    end
    fail_count++;
  endtask

  // Sign-extend an n-byte sample and scale it to full range, truncating towards zero.
  function automatic logic [SAMPLE_W-1:0] scale_to_s32(input logic [SAMPLE_W-1:0] raw,
                                                      input logic [NBYTES_W-1:0] nbytes);
    int unsigned bits;
    logic [63:0] mag;
    logic [63:0] scaled;
    logic        neg;
    if (nbytes >= NBYTES_FOUR) begin
      return raw;
    end
    bits = BYTE_W * nbytes;
    mag  = 64'(raw) & ((64'd1 << bits) - 64'd1);
    neg  = mag[bits-1];
    if (neg) begin
      mag = (64'd1 << bits) - mag;
    end
    scaled = (mag * FULL_SCALE) >> (bits - 1);
    if (neg) begin
      scaled = (64'd1 << SAMPLE_W) - scaled;
    end
    return scaled[SAMPLE_W-1:0];
  endfunction

  always @(posedge clk) begin : watch
    logic [SAMPLE_W-1:0] raw;
    sample_result_t      want;
    if (rst) begin
      size_now   = SAMPLE_BYTES_RESET;
      gathered   = '0;
      gather_pos = '0;
    end else begin
      // A new size always restarts on a sample boundary.
      if (cfg_valid && cfg_ready) begin
        size_now   = sample_bytes;
        gathered   = '0;
        gather_pos = '0;
      end
      if (in_valid && !in_stall) begin
        if (size_now < NBYTES_ONE || size_now > NBYTES_FOUR) begin
          gathered   = '0;
          gather_pos = '0;
        end else if (int'(gather_pos) + 1 >= int'(size_now)) begin
          raw = SAMPLE_W'(gathered) | (SAMPLE_W'(byte_value) << (BYTE_W * gather_pos));
          want.value = scale_to_s32(raw, size_now);
          want.last  = end_of_buffer;
          expected_samples.push_back(want);
          gathered   = '0;
          gather_pos = '0;
        end else begin
          gathered   = gathered | (PARTIAL_W'(byte_value) << (BYTE_W * gather_pos));
          gather_pos = gather_pos + 1'b1;
          if (end_of_buffer) begin
            gathered   = '0;
            gather_pos = '0;
          end
        end
      end
      if (out_valid && !out_stall) begin
        if (expected_samples.size() == 0) begin
          report_mismatch($sformatf("sample %h arrived with none expected", sample));
        end else begin
          want = expected_samples.pop_front();
          if (sample !== want.value) begin
            report_mismatch($sformatf("sample %h, expected %h", sample, want.value));
          end
          if (last_sample !== want.last) begin
            report_mismatch($sformatf("last_sample %b, expected %b", last_sample, want.last));
          end
        end
      end
    end
    pending_samples = expected_samples.size();
  end

endmodule

/* verif/tb_top.sv */
module tb_top;
  import pcmb_pkg::*;

  localparam int RANDOM_ITEMS = 800;
  localparam int PHASE_ITEMS  = 100;
  localparam int DRAIN_CYCLES = 4;

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  logic                       clk           = 1'b0;
  logic                       rst           = 1'b1;
  logic                       in_valid      = 1'b0;
  logic                       in_stall;
  logic [BYTE_W-1:0]          byte_value    = '0;
  logic                       end_of_buffer = 1'b0;
  logic                       cfg_valid     = 1'b0;
  logic                       cfg_ready;
  logic [NBYTES_W-1:0]        sample_bytes  = SAMPLE_BYTES_RESET;
  logic                       out_valid;
  logic                       out_stall     = 1'b0;
  logic signed [SAMPLE_W-1:0] sample;
  logic                       last_sample;

  int                  pending_samples;
  int                  fail_count;
  int                  tx_idle_pct  = 0;
  int                  rx_stall_pct = 0;
  int                  items_sent   = 0;
  logic [NBYTES_W-1:0] cur_size     = SAMPLE_BYTES_RESET;

  pcm_bytes_to_s32_samples_unit dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .byte_value    (byte_value),
    .end_of_buffer (end_of_buffer),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .sample_bytes  (sample_bytes),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .sample        (sample),
    .last_sample   (last_sample)
  );

  s32_sample_checker checker_i (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .byte_value      (byte_value),
    .end_of_buffer   (end_of_buffer),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .sample_bytes    (sample_bytes),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .sample          (sample),
    .last_sample     (last_sample),
    .pending_samples (pending_samples),
    .fail_count      (fail_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_stall <= !rst && ($urandom_range(99) < rx_stall_pct);
  end

  initial begin
    #5_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  task automatic set_idling(input idle_mode_t mode);
    case (mode)
      IDLE_NONE: begin
        tx_idle_pct = 0;  rx_stall_pct = 0;
      end
      IDLE_SENDER: begin
        tx_idle_pct = 79; rx_stall_pct = 0;
      end
      IDLE_RECEIVER: begin
        tx_idle_pct = 0;  rx_stall_pct = 79;
      end
      default: begin
        tx_idle_pct = 10; rx_stall_pct = 10;
      end
    endcase
  endtask

  // Stall is sampled mid-cycle, so the decision never races the accepting edge.
  task automatic send_byte(input logic [BYTE_W-1:0] b, input logic eob);
    logic taken;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    byte_value    <= b;
    end_of_buffer <= eob;
    do begin
      @(negedge clk);
      taken = !in_stall;
      @(posedge clk);
    end while (!taken);
    if (cur_size >= NBYTES_ONE && cur_size <= NBYTES_FOUR) begin
      items_sent++;
    end
  endtask

  // The size changes only once every expected sample is out and the pipeline has drained.
  task automatic write_size(input logic [NBYTES_W-1:0] size);
    logic taken;
    in_valid <= 1'b0;
    do @(negedge clk); while (pending_samples != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_valid    <= 1'b1;
    sample_bytes <= size;
    do begin
      @(negedge clk);
      taken = cfg_ready;
      @(posedge clk);
    end while (!taken);
    cfg_valid <= 1'b0;
    cur_size = size;
  endtask

  function automatic logic [BYTE_W-1:0] pick_byte();
    case ($urandom_range(7))
      0:       return 8'h00;
      1:       return 8'hFF;
      2:       return 8'h80;
      3:       return 8'h7F;
      default: return BYTE_W'($urandom);
    endcase
  endfunction

  // Mostly whole buffers of random samples; some cut short, some left open, some noise.
  task automatic send_buffer(input int unsigned n);
    int unsigned kind;
    int unsigned count;
    logic        close;
    kind = $urandom_range(9);
    if (kind == 0) begin
      count = $urandom_range(1, 12);
      for (int unsigned i = 0; i < count; i++) begin
        send_byte(pick_byte(), $urandom_range(3) == 0);
      end
    end else begin
      count = n * $urandom_range(1, 8);
      if (kind == 1 && n > 1) begin
        count = count - $urandom_range(1, n - 1);
      end
      close = (kind != 2);
      for (int unsigned i = 0; i < count; i++) begin
        send_byte(pick_byte(), close && (i == count - 1));
      end
    end
  endtask

  initial begin
    int               phase;
    int               target;
    logic [NBYTES_W-1:0] bad_size;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Two-byte samples straight out of reset: most negative, most positive,
    // then a partial sample dropped at the end of the buffer.
    send_byte(8'h00, 1'b0); send_byte(8'h80, 1'b0);
    send_byte(8'hFF, 1'b0); send_byte(8'h7F, 1'b0);
    send_byte(8'h01, 1'b1);

    write_size(NBYTES_ONE);
    send_byte(8'h80, 1'b0); send_byte(8'h7F, 1'b0);
    send_byte(8'h00, 1'b0); send_byte(8'hFF, 1'b1);

    write_size(NBYTES_THREE);
    send_byte(8'h00, 1'b0); send_byte(8'h00, 1'b0); send_byte(8'h80, 1'b0);
    send_byte(8'hFF, 1'b0); send_byte(8'hFF, 1'b0); send_byte(8'h7F, 1'b0);
    send_byte(8'h12, 1'b1);

    write_size(NBYTES_FOUR);
    send_byte(8'h00, 1'b0); send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0); send_byte(8'h80, 1'b0);
    send_byte(8'hFF, 1'b0); send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b0); send_byte(8'h7F, 1'b1);

    // Sizes outside one to four bytes: every byte is ignored.
    write_size(3'd0);
    send_byte(8'hAA, 1'b0);
    write_size(3'd7);
    send_byte(8'h55, 1'b1);

    items_sent = 0;
    phase      = 0;
    while (items_sent < RANDOM_ITEMS) begin
      set_idling(idle_mode_t'(phase % 4));
      if (phase % 3 == 2) begin
        bad_size = ($urandom_range(3) == 0) ? 3'd0 : NBYTES_W'($urandom_range(5, 7));
        write_size(bad_size);
        repeat (6) send_byte(pick_byte(), $urandom_range(1));
      end
      write_size(NBYTES_W'($urandom_range(1, 4)));
      target = items_sent + PHASE_ITEMS;
      while (items_sent < target) begin
        send_buffer(cur_size);
      end
      phase++;
    end
    in_valid <= 1'b0;

    do @(negedge clk); while (pending_samples != 0);
    repeat (DRAIN_CYCLES * 2) @(posedge clk);
    if (fail_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+hdl
hdl/pcmb_pkg.sv
hdl/pcmb_gather.sv
hdl/pcmb_scale.sv
hdl/pcm_bytes_to_s32_samples_unit.sv
verif/s32_sample_checker.sv
verif/tb_top.sv
